FILE: rtl/gsp_pkg.sv
// Shared types, constants and tables for the galaxy spiral pixel colorizer.
`default_nettype none
package gsp_pkg;
    localparam int CoordW = 10;
    localparam int DimW = 11;
    localparam int PhaseW = 16;
    localparam int CountW = 4;
    localparam int PairW = 48;
    localparam int ChanW = 8;
    localparam int TabLen = 24;
    localparam int CordW = 36;
    localparam int AccW = 32;
    localparam int SqW = 24;
    localparam int RootW = 28;
    localparam int DistW = 22;
    localparam logic [DistW-1:0] DistMax = 22'h3FFFFF;

    typedef enum logic [2:0] {
        REG_WIDTH = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_PHASE = 3'd2,
        REG_COUNT = 3'd3,
        REG_PAIR_A = 3'd4,
        REG_PAIR_B = 3'd5,
        REG_PAIR_C = 3'd6,
        REG_PAIR_D = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [CordW-1:0] x;
        logic signed [CordW-1:0] y;
        logic [AccW-1:0] z;
        logic [SqW+32-1:0] rem;
        logic [RootW-1:0] root;
        logic [SqW+32-1:0] sqv;
        logic [CoordW:0] w;
        logic zero_vec;
    } cell_data_t;

    function automatic logic [AccW-1:0] atan_turns(input int i);
        logic [AccW-1:0] t [TabLen];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
              32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        return t[i];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/gsp_stream_if.sv
// Valid/ready stream interface for pixel and color transfers.
`default_nettype none
interface gsp_stream_if #(parameter int W = 1);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/gsp_cell.sv
// One chain cell: an optional CORDIC vectoring step and a square-root digit step.
`default_nettype none
module gsp_cell
    import gsp_pkg::*;
#(
    parameter int STEP = 0,
    parameter bit DO_CORDIC = 1'b1,
    parameter int ROOT_BITS = 1
) (
    input wire logic clk,
    input wire logic en,
    input wire cell_data_t d_in,
    output cell_data_t d_out
);
    cell_data_t n;
    logic [SqW+32-1:0] trial;
    logic [SqW+32-1:0] rem_sh;
    localparam int Shift = 2 * (RootW - 1 - STEP);
    always_comb
    begin
        n = d_in;
        if (DO_CORDIC)
        begin
            if (!d_in.y[CordW-1])
            begin
                n.x = d_in.x + (d_in.y >>> STEP);
                n.y = d_in.y - (d_in.x >>> STEP);
                n.z = d_in.z + atan_turns(STEP);
            end
            else
            begin
                n.x = d_in.x - (d_in.y >>> STEP);
                n.y = d_in.y + (d_in.x >>> STEP);
                n.z = d_in.z - atan_turns(STEP);
            end
        end
        rem_sh = '0;
        trial = '0;
        if (STEP < ROOT_BITS)
        begin
            rem_sh = {d_in.rem[SqW+32-3:0], d_in.sqv[Shift+1 -: 2]};
            trial = {{(SqW+32-RootW-2){1'b0}}, d_in.root, 2'b01};
            if (rem_sh >= trial)
            begin
                n.rem = rem_sh - trial;
                n.root = {d_in.root[RootW-2:0], 1'b1};
            end
            else
            begin
                n.rem = rem_sh;
                n.root = {d_in.root[RootW-2:0], 1'b0};
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_out <= n;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/gsp_divider.sv
// Pipelined restoring divider of the root by the buffer width, one quotient bit per stage.
`default_nettype none
module gsp_divider
    import gsp_pkg::*;
#(
    parameter int NB = RootW,
    parameter int DW = CoordW + 1
) (
    input wire logic clk,
    input wire logic en,
    input wire logic [NB-1:0] num,
    input wire logic [DW-1:0] den,
    output logic [NB-1:0] quo
);
    logic [NB-1:0] q_reg [NB+1];
    logic [DW:0] r_reg [NB+1];
    logic [DW-1:0] d_reg [NB+1];
    always_comb
    begin
        q_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
    end
    for (genvar k = 0; k < NB; k++)
    begin : g_st
        logic [DW:0] sh;
        assign sh = {r_reg[k][DW-1:0], q_reg[k][NB-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k+1] <= d_reg[k];
                if (sh >= {1'b0, d_reg[k]})
                begin
                    r_reg[k+1] <= sh - {1'b0, d_reg[k]};
                    q_reg[k+1] <= {q_reg[k][NB-2:0], 1'b1};
                end
                else
                begin
                    r_reg[k+1] <= sh;
                    q_reg[k+1] <= {q_reg[k][NB-2:0], 1'b0};
                end
            end
        end
    end
    assign quo = q_reg[NB];
endmodule
`default_nettype wire

FILE: rtl/galaxy_spiral_pixel.sv
// Top level of the galaxy spiral pixel colorizer.
// One pixel transfer is accepted every clock unless the output stalls. The pipeline has one
// input register, one chain cell per square-root digit (28 cells, the first 16 of which also
// do the CORDIC steps), one divider stage per quotient bit (28), and three stages of palette
// lookup, blend and dimming. The whole pipeline advances whenever the output register is
// empty or being taken, so a stalled output holds every stage and the input.
`default_nettype none
module galaxy_spiral_pixel
    import gsp_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int ARM_COUNT = 3
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cfg_we,
    input wire logic [2:0] cfg_index,
    input wire logic [PairW-1:0] cfg_data,
    gsp_stream_if.sink pixel,
    gsp_stream_if.source colour
);
    localparam int Cells = RootW;
    localparam int Lat = 1 + Cells + RootW + 3;
    logic [DimW-1:0] width_reg, height_reg;
    logic [PhaseW-1:0] phase_reg;
    logic [CountW-1:0] count_reg;
    logic [PairW-1:0] pair_reg [4];
    logic en;
    logic [Lat-1:0] vld_reg;
    assign en = !colour.valid || colour.ready;
    assign pixel.ready = en;
    assign colour.valid = vld_reg[Lat-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd32;
            height_reg <= 11'd32;
            phase_reg <= '0;
            count_reg <= '0;
            for (int k = 0; k < 4; k++) pair_reg[k] <= '0;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_WIDTH: width_reg <= cfg_data[DimW-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[DimW-1:0];
                    REG_PHASE: phase_reg <= cfg_data[PhaseW-1:0];
                    REG_COUNT: count_reg <= cfg_data[CountW-1:0];
                    REG_PAIR_A: pair_reg[0] <= cfg_data;
                    REG_PAIR_B: pair_reg[1] <= cfg_data;
                    REG_PAIR_C: pair_reg[2] <= cfg_data;
                    REG_PAIR_D: pair_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
            if (en) vld_reg <= {vld_reg[Lat-2:0], pixel.valid};
        end
    end

    logic [CoordW:0] w, h;
    logic signed [CoordW+2:0] dx2, dy2;
    logic [SqW-1:0] sq;
    cell_data_t c0;
    assign w = (width_reg > 11'd1024) ? 11'd1024 : width_reg;
    assign h = (height_reg > 11'd1024) ? 11'd1024 : height_reg;
    always_comb
    begin
        dx2 = $signed({2'b0, pixel.data[CoordW-1:0], 1'b0}) - $signed({2'b0, w});
        dy2 = $signed({2'b0, pixel.data[2*CoordW-1:CoordW], 1'b0}) - $signed({2'b0, h});
        sq = SqW'(dx2 * dx2) + SqW'(dy2 * dy2);
        c0 = '0;
        c0.sqv = {sq, 32'b0};
        c0.w = w;
        c0.zero_vec = (dx2 == 0) && (dy2 == 0);
        if (dx2 < 0)
        begin
            c0.x = -(CordW'(dx2) <<< 16);
            c0.y = -(CordW'(dy2) <<< 16);
            c0.z = 32'h80000000;
        end
        else
        begin
            c0.x = CordW'(dx2) <<< 16;
            c0.y = CordW'(dy2) <<< 16;
        end
    end

    cell_data_t chain [Cells+1];
    always_ff @(posedge clk)
    begin
        if (en) chain[0] <= c0;
    end
    for (genvar k = 0; k < Cells; k++)
    begin : g_cell
        gsp_cell #(.STEP(k), .DO_CORDIC(k < CORDIC_STEPS && k < TabLen),
                   .ROOT_BITS(RootW)) u_cell (
            .clk(clk), .en(en), .d_in(chain[k]), .d_out(chain[k+1]));
    end

    logic [RootW-1:0] quo;
    gsp_divider u_div (.clk(clk), .en(en), .num(chain[Cells].root),
                       .den(chain[Cells].w), .quo(quo));
    logic [PhaseW-1:0] ang_d [RootW+1];
    logic wz_d [RootW+1];
    assign ang_d[0] = chain[Cells].zero_vec ? 16'd0 : chain[Cells].z[AccW-1:16];
    assign wz_d[0] = (chain[Cells].w == 0);
    for (genvar k = 0; k < RootW; k++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ang_d[k+1] <= ang_d[k];
                wz_d[k+1] <= wz_d[k];
            end
        end
    end

    logic [DistW-1:0] distance;
    logic [3:0] n;
    logic [PhaseW-1:0] spiral;
    logic [PhaseW+3:0] p;
    logic [2:0] ci, cj;
    logic [23:0] ca, cb;
    logic [PhaseW-1:0] f_reg;
    logic [23:0] a_reg, b_reg;
    logic [16:0] bright_reg, bright2_reg;
    logic zero_reg, zero2_reg;
    logic [ChanW-1:0] c_reg [3];
    logic [ChanW-1:0] out_reg [3];
    assign distance = wz_d[RootW] ? DistMax :
                      ((quo > RootW'(DistMax)) ? DistMax : quo[DistW-1:0]);
    assign n = (count_reg > 4'd8) ? 4'd8 : count_reg;
    always_comb
    begin
        spiral = PhaseW'(ARM_COUNT * ang_d[RootW]) + PhaseW'({distance, 1'b0}) + phase_reg;
        p = spiral * n;
        ci = (p[PhaseW+3:PhaseW] >= n) ? 3'(n - 4'd1) : p[PhaseW+2:PhaseW];
        cj = ({1'b0, ci} + 4'd1 == n) ? 3'd0 : ci + 3'd1;
        ca = pair_reg[ci[2:1]][ci[0]*24 +: 24];
        cb = pair_reg[cj[2:1]][cj[0]*24 +: 24];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg <= p[PhaseW-1:0];
            a_reg <= ca;
            b_reg <= cb;
            bright_reg <= (distance < 22'd65536) ? 17'(17'd65536 - distance) : 17'd0;
            zero_reg <= (n == 0);
            bright2_reg <= bright_reg;
            zero2_reg <= zero_reg;
            for (int k = 0; k < 3; k++)
                c_reg[k] <= ChanW'((25'(a_reg[16-8*k +: 8]) * (17'd65536 - f_reg)
                           + 25'(b_reg[16-8*k +: 8]) * f_reg) >> 16);
            for (int k = 0; k < 3; k++)
                out_reg[k] <= zero2_reg ? 8'd0 : ChanW'((25'(c_reg[k]) * bright2_reg) >> 16);
        end
    end
    assign colour.data = {out_reg[0], out_reg[1], out_reg[2]};
endmodule
`default_nettype wire

FILE: rtl/gsp_checker.sv
// Port-level checker for the galaxy spiral pixel colorizer and its bind.
`default_nettype none
module gsp_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [23:0] out_data
);
    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("ready while stalled");
    a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("not ready while output empty");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output dropped");
endmodule
bind galaxy_spiral_pixel gsp_checker u_chk (.clk(clk), .rst_n(rst_n),
    .in_valid(pixel.valid), .in_ready(pixel.ready), .out_valid(colour.valid),
    .out_ready(colour.ready), .out_data(colour.data));
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the galaxy spiral pixel colorizer.
`default_nettype none
module testbench;
    import gsp_pkg::*;

    localparam int Arms = 3;
    localparam int Steps = 16;
    localparam int DrainCycles = 100;
    localparam int WatchLimit = 5000;

    typedef struct packed {
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] x;
    } pixel_t;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } rgb_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [PairW-1:0] cfg_data = '0;

    gsp_stream_if #(.W(2 * CoordW)) pixel_if ();
    gsp_stream_if #(.W(3 * ChanW)) colour_if ();

    galaxy_spiral_pixel dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel(pixel_if.sink),
        .colour(colour_if.source)
    );

    // Shadow copy of the register file.
    int unsigned width_reg = 32;
    int unsigned height_reg = 32;
    int unsigned phase_reg = 0;
    int unsigned count_reg = 0;
    logic [PairW-1:0] pair_reg [4] = '{default: '0};

    pixel_t pending_pixels [$];
    rgb_t expected_colours [$];
    pixel_t current_pixel;
    int burst_left = 0;
    int gap_left = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int pattern_age = 0;

    function automatic rgb_t spiral_colour(pixel_t pix);
        longint unsigned atan_tab [16];
        longint w, h, n, dx2, dy2, sq, xs, ys, cx, cy;
        longint unsigned rem, bit_v, root, q, distance, ang, z, spiral, p, f, bright;
        longint unsigned ca, cb, c;
        int unsigned i, j, k;
        logic [23:0] col_a, col_b;
        rgb_t res;
        atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                     64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                     64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                     64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
        res = '0;
        n = (count_reg > 8) ? 8 : count_reg;
        if (n == 0)
            return res;
        w = (width_reg > 1024) ? 1024 : width_reg;
        h = (height_reg > 1024) ? 1024 : height_reg;
        dx2 = 2 * longint'(pix.x) - w;
        dy2 = 2 * longint'(pix.y) - h;
        sq = dx2 * dx2 + dy2 * dy2;
        if (w == 0) begin
            distance = 64'h3FFFFF;
        end else begin
            rem = longint'(sq) << 32;
            root = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > rem)
                bit_v = bit_v >> 2;
            while (bit_v != 0) begin
                if (rem >= root + bit_v) begin
                    rem = rem - (root + bit_v);
                    root = (root >> 1) + bit_v;
                end else begin
                    root = root >> 1;
                end
                bit_v = bit_v >> 2;
            end
            q = root / longint'(w);
            distance = (q > 64'h3FFFFF) ? 64'h3FFFFF : q;
        end
        if (dx2 == 0 && dy2 == 0) begin
            ang = 0;
        end else begin
            cx = dx2 * 65536;
            cy = dy2 * 65536;
            z = 0;
            if (cx < 0) begin
                cx = -cx;
                cy = -cy;
                z = 64'h80000000;
            end
            for (k = 0; k < Steps; k++) begin
                xs = cx >>> k;
                ys = cy >>> k;
                if (cy >= 0) begin
                    cx = cx + ys;
                    cy = cy - xs;
                    z = (z + atan_tab[k]) & 64'hFFFFFFFF;
                end else begin
                    cx = cx - ys;
                    cy = cy + xs;
                    z = (z - atan_tab[k]) & 64'hFFFFFFFF;
                end
            end
            ang = z >> 16;
        end
        spiral = (Arms * ang + 2 * distance + phase_reg) & 64'hFFFF;
        p = spiral * longint'(n);
        i = p >> 16;
        f = p & 64'hFFFF;
        if (i >= n)
            i = n - 1;
        j = (i + 1 == n) ? 0 : i + 1;
        col_a = pair_reg[(i >> 1) & 3] >> ((i & 1) * 24);
        col_b = pair_reg[(j >> 1) & 3] >> ((j & 1) * 24);
        bright = (distance < 65536) ? 65536 - distance : 0;
        for (k = 0; k < 3; k++) begin
            ca = (col_a >> (16 - 8 * k)) & 8'hFF;
            cb = (col_b >> (16 - 8 * k)) & 8'hFF;
            c = (ca * (65536 - f) + cb * f) >> 16;
            res[23 - 8 * k -: 8] = ((c * bright) >> 16) & 8'hFF;
        end
        return res;
    endfunction

    initial begin
        forever #4 clk = ~clk;
    end

    // Pixel driver: bursts of random length separated by random gaps.
    always @(posedge clk) begin
        logic busy;
        logic next_valid;
        pixel_t next_pixel;
        busy = pixel_if.valid;
        next_pixel = current_pixel;
        if (rst_n) begin
            if (pixel_if.valid && pixel_if.ready) begin
                expected_colours.push_back(spiral_colour(current_pixel));
                busy = 1'b0;
            end
            next_valid = busy;
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    next_valid = 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    next_pixel = pending_pixels.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end
            end
            current_pixel <= next_pixel;
            pixel_if.valid <= next_valid;
            pixel_if.data <= next_pixel;
        end
    end

    // Color monitor with its own stall pattern, plus the watchdog.
    always @(posedge clk) begin
        rgb_t got, want;
        logic moved;
        moved = 1'b0;
        if (rst_n) begin
            if (pixel_if.valid && pixel_if.ready)
                moved = 1'b1;
            if (colour_if.valid && colour_if.ready) begin
                moved = 1'b1;
                got = colour_if.data;
                if (expected_colours.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("Unexpected color transfer %h", got);
                end else begin
                    want = expected_colours.pop_front();
                    if (got !== want) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display({"Color mismatch: expected r=%h g=%h b=%h, ",
                                      "got r=%h g=%h b=%h"},
                                     want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
            pattern_age = pattern_age + 1;
            if (pattern_age == 64) begin
                pattern_age = 0;
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                if (stall_pattern == 0)
                    stall_pattern = 16'h0001;
            end
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            colour_if.ready <= stall_pattern[0];
            if (moved || (pending_pixels.size() == 0 && !pixel_if.valid
                          && expected_colours.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(reg_index_t idx, logic [PairW-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_WIDTH: width_reg = value[10:0];
            REG_HEIGHT: height_reg = value[10:0];
            REG_PHASE: phase_reg = value[15:0];
            REG_COUNT: count_reg = value[3:0];
            default: pair_reg[idx - REG_PAIR_A] = value;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() > 0 || pixel_if.valid || expected_colours.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic queue_pixel(int unsigned x, int unsigned y);
        pixel_t pix;
        pix.x = CoordW'(x);
        pix.y = CoordW'(y);
        pending_pixels.push_back(pix);
    endtask

    task automatic queue_corners();
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(0, 1023);
        queue_pixel(1023, 0);
        queue_pixel(width_reg / 2, height_reg / 2);
    endtask

    task automatic random_palette();
        write_reg(REG_PAIR_A, {$urandom, $urandom});
        write_reg(REG_PAIR_B, {$urandom, $urandom});
        write_reg(REG_PAIR_C, {$urandom, $urandom});
        write_reg(REG_PAIR_D, {$urandom, $urandom});
    endtask

    initial begin
        int unsigned wsel, hsel, span_x, span_y;
        pixel_if.valid = 1'b0;
        pixel_if.data = '0;
        colour_if.ready = 1'b0;
        current_pixel = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: the empty palette gives black.
        queue_corners();
        wait_idle();

        // Directed settings: single color, full and oversized palettes, extreme sizes.
        random_palette();
        write_reg(REG_COUNT, 1);
        write_reg(REG_PHASE, 16'hFFFF);
        queue_corners();
        queue_pixel(15, 16);
        wait_idle();
        write_reg(REG_COUNT, 8);
        write_reg(REG_WIDTH, 1024);
        write_reg(REG_HEIGHT, 1024);
        queue_corners();
        queue_pixel(512, 0);
        queue_pixel(0, 512);
        wait_idle();
        write_reg(REG_COUNT, 15);
        write_reg(REG_WIDTH, 2047);
        write_reg(REG_HEIGHT, 2047);
        write_reg(REG_PAIR_A, {PairW{1'b1}});
        queue_corners();
        wait_idle();
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 1);
        write_reg(REG_PHASE, 0);
        queue_corners();
        wait_idle();

        // Random phases, each with fresh settings.
        for (int ph = 0; ph < 20; ph++) begin
            wsel = $urandom_range(0, 9);
            hsel = $urandom_range(0, 9);
            write_reg(REG_WIDTH, (wsel == 0) ? $urandom_range(0, 2047)
                                 : (wsel == 1) ? 1024 : $urandom_range(1, 64));
            write_reg(REG_HEIGHT, (hsel == 0) ? $urandom_range(0, 2047)
                                  : (hsel == 1) ? 1 : $urandom_range(1, 64));
            write_reg(REG_PHASE, $urandom_range(0, 65535));
            write_reg(REG_COUNT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                 : $urandom_range(1, 8));
            random_palette();
            span_x = (width_reg > 1023) ? 1023 : width_reg;
            span_y = (height_reg > 1023) ? 1023 : height_reg;
            for (int k = 0; k < 80; k++) begin
                if ($urandom_range(0, 7) == 0)
                    queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
                else
                    queue_pixel($urandom_range(0, span_x), $urandom_range(0, span_y));
            end
            wait_idle();
        end

        if (mismatches == 0 && expected_colours.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
